[hw/rtl/mer_pkg.sv]
package mer_pkg;

	localparam int RADIUS_BITS  = 10;
	localparam int COORD_BITS   = 12;
	localparam int OUT_BITS     = 14;
	localparam int OFFX_BITS    = RADIUS_BITS + 1;
	localparam int OFFY_BITS    = RADIUS_BITS + 2;
	localparam int SQ_BITS      = 2 * RADIUS_BITS;
	localparam int TX_BITS      = OFFX_BITS + 1;
	localparam int TY_BITS      = OFFY_BITS - 1;
	localparam int SLOPE_BITS   = 34;
	localparam int DEC_BITS     = 48;
	localparam int TERM_BITS    = SLOPE_BITS + 2;
	localparam int MUL_A_BITS   = 32;
	localparam int MUL_B_BITS   = SQ_BITS;
	localparam int PROD_BITS    = MUL_A_BITS + MUL_B_BITS;
	localparam int CFG_IDX_BITS = 2;

	localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS_X = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS_Y = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_X = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Y = 2'd3;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP  = 1'b1;

	typedef struct packed {
		logic [RADIUS_BITS-1:0] radius_x;
		logic [RADIUS_BITS-1:0] radius_y;
		logic [COORD_BITS-1:0]  center_x;
		logic [COORD_BITS-1:0]  center_y;
	} cfg_t;

	typedef struct packed {
		logic [MUL_A_BITS-1:0] a;
		logic [MUL_B_BITS-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic active;
		logic region_two;
	} stat_t;

endpackage

[hw/rtl/mer_cmd_if.sv]
interface mer_cmd_if;
	logic valid;
	logic ready;
	logic command;
	logic swap_axes;

	modport source (output valid, output command, output swap_axes, input ready);
	modport sink (input valid, input command, input swap_axes, output ready);
endinterface

[hw/rtl/mer_pts_if.sv]
interface mer_pts_if;
	logic                                valid;
	logic                                ready;
	logic                                valid_res;
	logic signed [mer_pkg::OUT_BITS-1:0] left_x;
	logic signed [mer_pkg::OUT_BITS-1:0] right_x;
	logic signed [mer_pkg::OUT_BITS-1:0] low_y;
	logic signed [mer_pkg::OUT_BITS-1:0] high_y;
	logic                                last;

	modport source (
		output valid, output valid_res, output left_x, output right_x,
		output low_y, output high_y, output last, input ready
	);
	modport sink (
		input valid, input valid_res, input left_x, input right_x,
		input low_y, input high_y, input last, output ready
	);
endinterface

[hw/rtl/midpoint_ellipse_rasterizer.sv]
// step beat: CHECK, ADV1, ADV2, ready; result registered in ADV1 once output is free
// start beat: 3 dependent products on the shared multiplier
// a step that crosses into region two adds 5 more products
// step while idle: a null result through NULL, one item in flight at a time
// asynchronous active-low reset clears the sequencer, the walk flags, the config and the output valid

module midpoint_ellipse_rasterizer (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mer_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [mer_pkg::COORD_BITS-1:0]   cfg_data,
	mer_cmd_if.sink                          cmd,
	mer_pts_if.source                        pts
);

	mer_pkg::cfg_t                 cfg_q;
	mer_pkg::mul_req_t             req;
	logic [mer_pkg::PROD_BITS-1:0] prod_s1;
	mer_pkg::stat_t                stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mer_pkg::REG_RADIUS_X: cfg_q.radius_x <= cfg_data[mer_pkg::RADIUS_BITS-1:0];
				mer_pkg::REG_RADIUS_Y: cfg_q.radius_y <= cfg_data[mer_pkg::RADIUS_BITS-1:0];
				mer_pkg::REG_CENTER_X: cfg_q.center_x <= cfg_data;
				mer_pkg::REG_CENTER_Y: cfg_q.center_y <= cfg_data;
			endcase
		end
	end

	mer_mul u_mul (
		.clk     (clk),
		.req     (req),
		.prod_s1 (prod_s1)
	);

	mer_walk u_walk (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.cmd     (cmd),
		.pts     (pts),
		.req     (req),
		.prod_s1 (prod_s1),
		.stat    (stat)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		pts.valid && pts.last |-> pts.valid_res)
		else $error("last flag on a null result");

	assert property (@(posedge clk) disable iff (!arst_n)
		pts.valid && !pts.valid_res |-> (pts.left_x == '0) && (pts.right_x == '0)
			&& (pts.low_y == '0) && (pts.high_y == '0) && !pts.last)
		else $error("null result carries nonzero fields");

	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(stat.region_two) |-> stat.active && !cmd.ready)
		else $error("region change outside an active walk");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> !cmd.ready)
		else $error("second beat taken while an item is in flight");

endmodule

[hw/rtl/mer_mul.sv]
module mer_mul (
	input  logic                           clk,
	input  mer_pkg::mul_req_t              req,
	output logic [mer_pkg::PROD_BITS-1:0]  prod_s1
);

	always_ff @(posedge clk) begin
		prod_s1 <= mer_pkg::PROD_BITS'(req.a) * mer_pkg::PROD_BITS'(req.b);
	end

endmodule

[hw/rtl/mer_walk.sv]
module mer_walk (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mer_pkg::cfg_t                 cfg,
	mer_cmd_if.sink                       cmd,
	mer_pts_if.source                     pts,
	output mer_pkg::mul_req_t             req,
	input  logic [mer_pkg::PROD_BITS-1:0] prod_s1,
	output mer_pkg::stat_t                stat
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL   = 3'd1;
	localparam logic [2:0] ST_CHECK = 3'd2;
	localparam logic [2:0] ST_ADV1  = 3'd3;
	localparam logic [2:0] ST_ADV2  = 3'd4;
	localparam logic [2:0] ST_NULL  = 3'd5;

	localparam logic [2:0] OP_A2   = 3'd0;
	localparam logic [2:0] OP_B2   = 3'd1;
	localparam logic [2:0] OP_SY   = 3'd2;
	localparam logic [2:0] OP_BTX  = 3'd3;
	localparam logic [2:0] OP_BTX2 = 3'd4;
	localparam logic [2:0] OP_AY   = 3'd5;
	localparam logic [2:0] OP_AY2  = 3'd6;
	localparam logic [2:0] OP_AB   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] op_q;
	logic       phase_q;
	logic       active_q;
	logic       region_two_q;
	logic       pv_q;

	logic [mer_pkg::RADIUS_BITS-1:0]       eff_rx_q;
	logic [mer_pkg::RADIUS_BITS-1:0]       eff_ry_q;
	logic [mer_pkg::SQ_BITS-1:0]           a2_q;
	logic [mer_pkg::SQ_BITS-1:0]           b2_q;
	logic [mer_pkg::MUL_A_BITS-1:0]        m_q;
	logic [mer_pkg::OFFX_BITS-1:0]         off_x_q;
	logic signed [mer_pkg::OFFY_BITS-1:0]  off_y_q;
	logic signed [mer_pkg::SLOPE_BITS-1:0] sx_q;
	logic signed [mer_pkg::SLOPE_BITS-1:0] sy_q;
	logic signed [mer_pkg::DEC_BITS-1:0]   dec_q;
	logic signed [mer_pkg::TERM_BITS-1:0]  term_q;

	logic                                vres_q;
	logic signed [mer_pkg::OUT_BITS-1:0] lx_q;
	logic signed [mer_pkg::OUT_BITS-1:0] rx_q;
	logic signed [mer_pkg::OUT_BITS-1:0] ly_q;
	logic signed [mer_pkg::OUT_BITS-1:0] hy_q;
	logic                                last_q;

	logic in_acc;
	logic start_go;
	logic out_free;
	logic mul_done;
	logic adv1_go;
	logic adv2_go;
	logic null_go;
	logic need_r2;
	logic last_n;

	logic [mer_pkg::TX_BITS-1:0]           tx;
	logic [mer_pkg::OFFY_BITS-1:0]         ty_dec;
	logic [mer_pkg::TY_BITS-1:0]           ty_abs;
	logic [mer_pkg::RADIUS_BITS-1:0]       sel_rx;
	logic [mer_pkg::RADIUS_BITS-1:0]       sel_ry;
	logic [mer_pkg::SQ_BITS+mer_pkg::RADIUS_BITS-1:0] sy_half;
	logic signed [mer_pkg::SLOPE_BITS-1:0] two_a2;
	logic signed [mer_pkg::SLOPE_BITS-1:0] two_b2;
	logic signed [mer_pkg::SLOPE_BITS-1:0] sx_inc;
	logic signed [mer_pkg::SLOPE_BITS-1:0] sy_dec;
	logic signed [mer_pkg::TERM_BITS-1:0]  a2_t;
	logic signed [mer_pkg::TERM_BITS-1:0]  b2_t;

	logic [mer_pkg::OFFX_BITS-1:0]         ox_n;
	logic signed [mer_pkg::OFFY_BITS-1:0]  oy_n;
	logic signed [mer_pkg::SLOPE_BITS-1:0] sx_n;
	logic signed [mer_pkg::SLOPE_BITS-1:0] sy_n;
	logic signed [mer_pkg::TERM_BITS-1:0]  term_n;

	logic signed [mer_pkg::OUT_BITS-1:0] lx_n;
	logic signed [mer_pkg::OUT_BITS-1:0] rx_n;
	logic signed [mer_pkg::OUT_BITS-1:0] ly_n;
	logic signed [mer_pkg::OUT_BITS-1:0] hy_n;

	assign cmd.ready = (state_q == ST_IDLE);
	assign in_acc    = cmd.valid && cmd.ready;
	assign start_go  = in_acc && (cmd.command == mer_pkg::CMD_START);
	assign out_free  = !pv_q || pts.ready;
	assign mul_done  = (state_q == ST_MUL) && phase_q;
	assign adv1_go   = (state_q == ST_ADV1) && out_free;
	assign adv2_go   = (state_q == ST_ADV2);
	assign null_go   = (state_q == ST_NULL) && out_free;
	assign need_r2   = !region_two_q && (sx_q >= sy_q);
	assign last_n    = region_two_q && (off_y_q == '0);

	assign stat.active     = active_q;
	assign stat.region_two = region_two_q;

	assign sel_rx = cmd.swap_axes ? cfg.radius_y : cfg.radius_x;
	assign sel_ry = cmd.swap_axes ? cfg.radius_x : cfg.radius_y;

	// operands for the region change: 2x+1 and |y-1|
	assign tx     = {off_x_q, 1'b1};
	assign ty_dec = off_y_q - mer_pkg::OFFY_BITS'(1);
	assign ty_abs = (off_y_q == '0) ? mer_pkg::TY_BITS'(1) : ty_dec[mer_pkg::TY_BITS-1:0];

	assign sy_half = prod_s1[mer_pkg::SQ_BITS+mer_pkg::RADIUS_BITS-1:0];

	assign two_a2 = mer_pkg::SLOPE_BITS'({a2_q, 1'b0});
	assign two_b2 = mer_pkg::SLOPE_BITS'({b2_q, 1'b0});
	assign sx_inc = sx_q + two_b2;
	assign sy_dec = sy_q - two_a2;
	assign a2_t   = mer_pkg::TERM_BITS'(a2_q);
	assign b2_t   = mer_pkg::TERM_BITS'(b2_q);

	always_comb begin
		req = '0;
		unique case (op_q)
			OP_A2: begin
				req.a = mer_pkg::MUL_A_BITS'(eff_rx_q);
				req.b = mer_pkg::MUL_B_BITS'(eff_rx_q);
			end
			OP_B2: begin
				req.a = mer_pkg::MUL_A_BITS'(eff_ry_q);
				req.b = mer_pkg::MUL_B_BITS'(eff_ry_q);
			end
			OP_SY: begin
				req.a = mer_pkg::MUL_A_BITS'(a2_q);
				req.b = mer_pkg::MUL_B_BITS'(eff_ry_q);
			end
			OP_BTX: begin
				req.a = mer_pkg::MUL_A_BITS'(b2_q);
				req.b = mer_pkg::MUL_B_BITS'(tx);
			end
			OP_BTX2: begin
				req.a = m_q;
				req.b = mer_pkg::MUL_B_BITS'(tx);
			end
			OP_AY: begin
				req.a = mer_pkg::MUL_A_BITS'(a2_q);
				req.b = mer_pkg::MUL_B_BITS'(ty_abs);
			end
			OP_AY2: begin
				req.a = m_q;
				req.b = mer_pkg::MUL_B_BITS'(ty_abs);
			end
			OP_AB: begin
				req.a = mer_pkg::MUL_A_BITS'(a2_q);
				req.b = mer_pkg::MUL_B_BITS'(b2_q);
			end
		endcase
	end

	// one midpoint step, the decision term is applied in the cycle after the step
	always_comb begin
		ox_n   = off_x_q;
		oy_n   = off_y_q;
		sx_n   = sx_q;
		sy_n   = sy_q;
		term_n = '0;
		if (!region_two_q) begin
			ox_n = off_x_q + mer_pkg::OFFX_BITS'(1);
			sx_n = sx_inc;
			if (dec_q[mer_pkg::DEC_BITS-1]) begin
				term_n = mer_pkg::TERM_BITS'(sx_inc) + b2_t;
			end else begin
				oy_n   = off_y_q - mer_pkg::OFFY_BITS'(1);
				sy_n   = sy_dec;
				term_n = mer_pkg::TERM_BITS'(sx_inc) - mer_pkg::TERM_BITS'(sy_dec) + b2_t;
			end
		end else begin
			oy_n = off_y_q - mer_pkg::OFFY_BITS'(1);
			sy_n = sy_dec;
			if (!dec_q[mer_pkg::DEC_BITS-1] && (dec_q != '0)) begin
				term_n = a2_t - mer_pkg::TERM_BITS'(sy_dec);
			end else begin
				ox_n   = off_x_q + mer_pkg::OFFX_BITS'(1);
				sx_n   = sx_inc;
				term_n = mer_pkg::TERM_BITS'(sx_inc) - mer_pkg::TERM_BITS'(sy_dec) + a2_t;
			end
		end
	end

	assign lx_n = mer_pkg::OUT_BITS'(cfg.center_x) - mer_pkg::OUT_BITS'(off_x_q);
	assign rx_n = mer_pkg::OUT_BITS'(cfg.center_x) + mer_pkg::OUT_BITS'(off_x_q);
	assign ly_n = mer_pkg::OUT_BITS'(cfg.center_y) - mer_pkg::OUT_BITS'(off_y_q);
	assign hy_n = mer_pkg::OUT_BITS'(cfg.center_y) + mer_pkg::OUT_BITS'(off_y_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			op_q         <= OP_A2;
			phase_q      <= 1'b0;
			active_q     <= 1'b0;
			region_two_q <= 1'b0;
			pv_q         <= 1'b0;
		end else begin
			if (pts.ready && !adv1_go && !null_go) begin
				pv_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (cmd.command == mer_pkg::CMD_START) begin
							active_q     <= 1'b1;
							region_two_q <= 1'b0;
							op_q         <= OP_A2;
							phase_q      <= 1'b0;
							state_q      <= ST_MUL;
						end else if (active_q) begin
							state_q <= ST_CHECK;
						end else begin
							state_q <= ST_NULL;
						end
					end
				end
				ST_MUL: begin
					phase_q <= !phase_q;
					if (phase_q) begin
						unique case (op_q)
							OP_A2:   op_q <= OP_B2;
							OP_B2:   op_q <= OP_SY;
							OP_SY:   state_q <= ST_CHECK;
							OP_BTX:  op_q <= OP_BTX2;
							OP_BTX2: op_q <= OP_AY;
							OP_AY:   op_q <= OP_AY2;
							OP_AY2:  op_q <= OP_AB;
							OP_AB: begin
								region_two_q <= 1'b1;
								state_q      <= ST_ADV1;
							end
						endcase
					end
				end
				ST_CHECK: begin
					if (need_r2) begin
						op_q    <= OP_BTX;
						phase_q <= 1'b0;
						state_q <= ST_MUL;
					end else begin
						state_q <= ST_ADV1;
					end
				end
				ST_ADV1: begin
					if (out_free) begin
						pv_q <= 1'b1;
						if (last_n) begin
							active_q <= 1'b0;
						end
						state_q <= ST_ADV2;
					end
				end
				ST_ADV2: begin
					state_q <= ST_IDLE;
				end
				ST_NULL: begin
					if (out_free) begin
						pv_q    <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start_go) begin
			eff_rx_q <= sel_rx;
			eff_ry_q <= sel_ry;
			off_x_q  <= '0;
			off_y_q  <= mer_pkg::OFFY_BITS'(sel_ry);
			sx_q     <= '0;
		end
		if (mul_done) begin
			unique case (op_q)
				OP_A2:   a2_q <= prod_s1[mer_pkg::SQ_BITS-1:0];
				OP_B2:   b2_q <= prod_s1[mer_pkg::SQ_BITS-1:0];
				OP_SY: begin
					sy_q  <= mer_pkg::SLOPE_BITS'({sy_half, 1'b0});
					dec_q <= mer_pkg::DEC_BITS'({b2_q, 2'b00})
						- mer_pkg::DEC_BITS'({sy_half, 2'b00})
						+ mer_pkg::DEC_BITS'(a2_q);
				end
				OP_BTX:  m_q <= prod_s1[mer_pkg::MUL_A_BITS-1:0];
				OP_BTX2: dec_q <= mer_pkg::DEC_BITS'(prod_s1);
				OP_AY:   m_q <= prod_s1[mer_pkg::MUL_A_BITS-1:0];
				OP_AY2:  dec_q <= dec_q + mer_pkg::DEC_BITS'({prod_s1, 2'b00});
				OP_AB:   dec_q <= dec_q - mer_pkg::DEC_BITS'({prod_s1, 2'b00});
			endcase
		end
		if (adv1_go) begin
			off_x_q <= ox_n;
			off_y_q <= oy_n;
			sx_q    <= sx_n;
			sy_q    <= sy_n;
			term_q  <= term_n;
			vres_q  <= 1'b1;
			lx_q    <= lx_n;
			rx_q    <= rx_n;
			ly_q    <= ly_n;
			hy_q    <= hy_n;
			last_q  <= last_n;
		end
		if (adv2_go) begin
			dec_q <= dec_q + (mer_pkg::DEC_BITS'(term_q) <<< 2);
		end
		if (null_go) begin
			vres_q <= 1'b0;
			lx_q   <= '0;
			rx_q   <= '0;
			ly_q   <= '0;
			hy_q   <= '0;
			last_q <= 1'b0;
		end
	end

	assign pts.valid     = pv_q;
	assign pts.valid_res = vres_q;
	assign pts.left_x    = lx_q;
	assign pts.right_x   = rx_q;
	assign pts.low_y     = ly_q;
	assign pts.high_y    = hy_q;
	assign pts.last      = last_q;

endmodule

[bench/midpoint_ellipse_rasterizer_test.sv]
`timescale 1ns / 1ps

module midpoint_ellipse_rasterizer_test;
	import mer_pkg::*;

	localparam int STALL_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 24;
	localparam int RANDOM_SETS  = 700;
	localparam int WALK_MAX     = 150;

	typedef struct packed {
		logic                       valid_res;
		logic signed [OUT_BITS-1:0] left_x;
		logic signed [OUT_BITS-1:0] right_x;
		logic signed [OUT_BITS-1:0] low_y;
		logic signed [OUT_BITS-1:0] high_y;
		logic                       last;
	} pts_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [COORD_BITS-1:0]   cfg_data;

	mer_cmd_if cmd_bus ();
	mer_pts_if pts_bus ();

	midpoint_ellipse_rasterizer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd_bus),
		.pts       (pts_bus)
	);

	always #4 clk = ~clk;

	// register copies
	logic [RADIUS_BITS-1:0] reg_rx = '0;
	logic [RADIUS_BITS-1:0] reg_ry = '0;
	logic [COORD_BITS-1:0]  reg_cx = '0;
	logic [COORD_BITS-1:0]  reg_cy = '0;

	// quadrant walk state
	logic                         walking = 1'b0;
	logic                         in_lower = 1'b0;
	logic [RADIUS_BITS-1:0]       rad_a = '0;
	logic [RADIUS_BITS-1:0]       rad_b = '0;
	logic [OFFX_BITS-1:0]         pos_x = '0;
	logic signed [OFFY_BITS-1:0]  pos_y = '0;
	logic signed [SLOPE_BITS-1:0] grad_x = '0;
	logic signed [SLOPE_BITS-1:0] grad_y = '0;
	logic signed [DEC_BITS-1:0]   crit = '0;

	pts_t points_due[$];
	int   faults = 0;
	int   drawn_sets = 0;
	int   idle_cycles = 0;
	bit   calm = 1'b0;

	function automatic pts_t plot_next(input logic command, input logic swap_axes);
		longint a2, b2, rb, tx, ty, px, py;
		pts_t p;
		p = '0;
		if (command == CMD_START) begin
			rad_a = swap_axes ? reg_ry : reg_rx;
			rad_b = swap_axes ? reg_rx : reg_ry;
		end else if (!walking) begin
			return p;
		end
		a2 = longint'(rad_a) * longint'(rad_a);
		b2 = longint'(rad_b) * longint'(rad_b);
		if (command == CMD_START) begin
			rb = longint'(rad_b);
			pos_x = '0;
			pos_y = OFFY_BITS'(rb);
			grad_x = '0;
			grad_y = SLOPE_BITS'(2 * a2 * rb);
			crit = DEC_BITS'(4 * b2 - 4 * a2 * rb + a2);
			in_lower = 1'b0;
			walking = 1'b1;
		end
		// slope crossing: switch to stepping in y
		if (!in_lower && grad_x >= grad_y) begin
			tx = 2 * longint'(pos_x) + 1;
			ty = longint'(pos_y) - 1;
			crit = DEC_BITS'(b2 * tx * tx + 4 * a2 * ty * ty - 4 * a2 * b2);
			in_lower = 1'b1;
		end
		px = longint'(pos_x);
		py = longint'(pos_y);
		if (!in_lower) begin
			pos_x = pos_x + 1'b1;
			grad_x = grad_x + 2 * b2;
			if (crit < 0) begin
				crit = crit + 4 * grad_x + 4 * b2;
			end else begin
				pos_y = pos_y - 1;
				grad_y = grad_y - 2 * a2;
				crit = crit + 4 * (grad_x - grad_y) + 4 * b2;
			end
		end else begin
			pos_y = pos_y - 1;
			grad_y = grad_y - 2 * a2;
			if (crit > 0) begin
				crit = crit + 4 * a2 - 4 * grad_y;
			end else begin
				pos_x = pos_x + 1'b1;
				grad_x = grad_x + 2 * b2;
				crit = crit + 4 * (grad_x - grad_y) + 4 * a2;
			end
			if (pos_y < 0) begin
				walking = 1'b0;
				p.last = 1'b1;
			end
		end
		p.valid_res = 1'b1;
		p.left_x = OUT_BITS'(longint'(reg_cx) - px);
		p.right_x = OUT_BITS'(longint'(reg_cx) + px);
		p.low_y = OUT_BITS'(longint'(reg_cy) - py);
		p.high_y = OUT_BITS'(longint'(reg_cy) + py);
		return p;
	endfunction

	task automatic send_command(input logic command, input logic swap_axes);
		int   gap;
		pts_t want;
		gap = calm ? 0 : $urandom_range(0, 18);
		@(negedge clk);
		if (gap > 0) begin
			cmd_bus.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_bus.valid <= 1'b1;
		cmd_bus.command <= command;
		cmd_bus.swap_axes <= swap_axes;
		@(posedge clk);
		while (!cmd_bus.ready) @(posedge clk);
		want = plot_next(command, swap_axes);
		points_due.push_back(want);
		if (want.valid_res) drawn_sets++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] index,
			input logic [COORD_BITS-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (index)
			REG_RADIUS_X: reg_rx = data[RADIUS_BITS-1:0];
			REG_RADIUS_Y: reg_ry = data[RADIUS_BITS-1:0];
			REG_CENTER_X: reg_cx = data;
			REG_CENTER_Y: reg_cy = data;
		endcase
	endtask

	task automatic settle();
		@(negedge clk);
		cmd_bus.valid <= 1'b0;
		while (points_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// step until the ellipse ends, or only a few sets of a large one
	task automatic walk_on();
		int steps_left;
		steps_left = (rad_a > WALK_MAX || rad_b > WALK_MAX) ? $urandom_range(4, 40) : 1 << 30;
		while (walking && steps_left > 0) begin
			send_command(CMD_STEP, 1'($urandom_range(0, 1)));
			steps_left--;
		end
	endtask

	task automatic check_field(input string name, input logic signed [63:0] want,
			input logic signed [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			faults++;
		end
	endtask

	task automatic test_idle_steps();
		send_command(CMD_STEP, 1'b0);
		send_command(CMD_STEP, 1'b1);
	endtask

	task automatic test_degenerate_radii();
		settle();
		write_reg(REG_RADIUS_X, '0);
		write_reg(REG_RADIUS_Y, '0);
		send_command(CMD_START, 1'b0);
		send_command(CMD_STEP, 1'b0);
		settle();
		write_reg(REG_RADIUS_X, 12'd3);
		send_command(CMD_START, 1'b0);
		send_command(CMD_START, 1'b1);
		walk_on();
	endtask

	task automatic test_extremes();
		settle();
		write_reg(REG_RADIUS_X, 12'hFFF);
		write_reg(REG_RADIUS_Y, 12'd1023);
		write_reg(REG_CENTER_X, '0);
		write_reg(REG_CENTER_Y, '0);
		send_command(CMD_START, 1'b1);
		repeat (2) send_command(CMD_STEP, 1'b0);
		// center is read live on every set
		settle();
		write_reg(REG_CENTER_X, 12'hFFF);
		write_reg(REG_CENTER_Y, 12'hFFF);
		repeat (2) send_command(CMD_STEP, 1'b1);
		// radii stay latched while walking
		settle();
		write_reg(REG_RADIUS_X, 12'd2);
		write_reg(REG_RADIUS_Y, 12'd1);
		send_command(CMD_STEP, 1'b0);
		send_command(CMD_START, 1'b0);
		walk_on();
		send_command(CMD_STEP, 1'b0);
	endtask

	task automatic test_random_walks();
		int                      mode;
		int                      pick;
		logic [CFG_IDX_BITS-1:0] idx;
		logic [COORD_BITS-1:0]   data;
		while (drawn_sets < RANDOM_SETS) begin
			settle();
			calm = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(0, 4)) begin
				idx = CFG_IDX_BITS'($urandom_range(0, 3));
				pick = $urandom_range(0, 15);
				if (idx == REG_RADIUS_X || idx == REG_RADIUS_Y) begin
					case (pick)
						0: data = '0;
						1: data = COORD_BITS'($urandom_range(0, 4095));
						2: data = COORD_BITS'($urandom_range(25, WALK_MAX));
						default: data = COORD_BITS'($urandom_range(1, 24));
					endcase
				end else begin
					case (pick)
						0: data = '0;
						1: data = 12'hFFF;
						default: data = COORD_BITS'($urandom_range(0, 4095));
					endcase
				end
				write_reg(idx, data);
			end
			mode = $urandom_range(0, 9);
			if (mode <= 6) begin
				send_command(CMD_START, 1'($urandom_range(0, 1)));
				walk_on();
				if ($urandom_range(0, 3) == 0) send_command(CMD_STEP, 1'b0);
			end else if (mode == 7) begin
				repeat ($urandom_range(1, 20)) send_command(CMD_STEP, 1'($urandom_range(0, 1)));
			end else if (mode == 8) begin
				// restart in the middle of a walk
				send_command(CMD_START, 1'($urandom_range(0, 1)));
				repeat ($urandom_range(0, 5)) send_command(CMD_STEP, 1'b0);
				send_command(CMD_START, 1'($urandom_range(0, 1)));
				walk_on();
			end else begin
				repeat ($urandom_range(1, 8))
					send_command(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end
		end
	endtask

	initial begin : points_sink
		int   gap;
		pts_t want;
		pts_bus.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			gap = calm ? 0 : $urandom_range(0, 18);
			@(negedge clk);
			if (gap > 0) begin
				pts_bus.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			pts_bus.ready <= 1'b1;
			@(posedge clk);
			while (!pts_bus.valid) @(posedge clk);
			if (points_due.size() == 0) begin
				$display("%0t: points beat with nothing pending", $time);
				faults++;
			end else begin
				want = points_due.pop_front();
				check_field("valid_res", want.valid_res, pts_bus.valid_res);
				check_field("left_x", want.left_x, pts_bus.left_x);
				check_field("right_x", want.right_x, pts_bus.right_x);
				check_field("low_y", want.low_y, pts_bus.low_y);
				check_field("high_y", want.high_y, pts_bus.high_y);
				check_field("last", want.last, pts_bus.last);
			end
		end
	end

	always @(posedge clk) begin
		if ((cmd_bus.valid && cmd_bus.ready) || (pts_bus.valid && pts_bus.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		cmd_bus.valid <= 1'b0;
		cmd_bus.command <= CMD_START;
		cmd_bus.swap_axes <= 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_idle_steps();
		test_degenerate_radii();
		test_extremes();
		test_random_walks();
		settle();
		if (faults == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
